// File: hdl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_RES   = 16;

  localparam int OP_W    = 2;
  localparam int TASK_W  = 16;
  localparam int DELAY_W = 32;
  localparam int CNT_W   = 16;
  localparam int KIND_W  = 2;

  localparam int IN_TDATA_W  = 104;  // 98 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 24;   // 17 bits of fields, padded to bytes

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT,
    ST_FINISH
  } ptt_state_t;

  typedef struct packed {
    logic load;    // capture the input beat, rewind the walk
    logic walk;    // sweep the slot table
    logic commit;  // write back the insert/remove result
    logic finish;  // hand the closing result to the output register
  } ptt_cmd_t;

  typedef struct packed {
    logic            walk_done;
    logic            out_free;
    logic [OP_W-1:0] op;
  } ptt_stat_t;

endpackage

`default_nettype wire

// File: hdl/ptt_ctrl.sv
`default_nettype none

module ptt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  ptt_pkg::ptt_stat_t  stat,
  output ptt_pkg::ptt_cmd_t   cmd
);

  ptt_pkg::ptt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ptt_pkg::ST_WALK;
      end
      ptt_pkg::ST_WALK: begin
        if (stat.walk_done) begin
          if (stat.op == ptt_pkg::OP_INSERT || stat.op == ptt_pkg::OP_REMOVE) begin
            state_nxt = ptt_pkg::ST_COMMIT;
          end else begin
            state_nxt = ptt_pkg::ST_FINISH;
          end
        end
      end
      ptt_pkg::ST_COMMIT: begin
        state_nxt = ptt_pkg::ST_FINISH;
      end
      ptt_pkg::ST_FINISH: begin
        if (stat.out_free) state_nxt = ptt_pkg::ST_IDLE;
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ptt_pkg::ST_WALK:   cmd.walk   = 1'b1;
      ptt_pkg::ST_COMMIT: cmd.commit = 1'b1;
      ptt_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ptt_dp.sv
`default_nettype none

module ptt_dp #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  ptt_pkg::ptt_cmd_t                  cmd,
  output ptt_pkg::ptt_stat_t                 stat,
  input  wire [ptt_pkg::OP_W-1:0]            in_opcode,
  input  wire [ptt_pkg::TASK_W-1:0]          in_task_id,
  input  wire [ptt_pkg::DELAY_W-1:0]         in_delay,
  input  wire signed [ptt_pkg::CNT_W-1:0]    in_repeat,
  input  wire [ptt_pkg::DELAY_W-1:0]         in_elapsed,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [ptt_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_ok,
  output logic [ptt_pkg::TASK_W-1:0]         out_task,
  output logic                               out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(ptt_pkg::MAX_RES + 1);
  localparam logic [CW-1:0] END_CNT  = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [NW-1:0] RES_CAP  = NW'(ptt_pkg::MAX_RES);

  // captured item
  logic [ptt_pkg::OP_W-1:0]         op_r;
  logic [ptt_pkg::TASK_W-1:0]       id_r;
  logic [ptt_pkg::DELAY_W-1:0]      delay_r;
  logic signed [ptt_pkg::CNT_W-1:0] rc_r;
  logic [ptt_pkg::DELAY_W-1:0]      el_r;

  // slot table
  logic [ptt_pkg::TASK_W-1:0]       mem_task   [SLOTS];
  logic [ptt_pkg::DELAY_W-1:0]      mem_reload [SLOTS];
  logic [ptt_pkg::DELAY_W-1:0]      mem_rem    [SLOTS];
  logic [ptt_pkg::CNT_W-1:0]        mem_cnt    [SLOTS];
  logic [SLOTS-1:0]                 slot_vld_r;

  // walk pipeline
  logic [CW-1:0]                    rd_cnt_r;
  logic [IW-1:0]                    rd_idx;
  logic                             iss, adv, stall, p_go;
  logic                             p_vld_r;
  logic [IW-1:0]                    p_idx_r;
  logic                             rd_v_r;
  logic [ptt_pkg::TASK_W-1:0]       rd_task_r;
  logic [ptt_pkg::DELAY_W-1:0]      rd_reload_r;
  logic [ptt_pkg::DELAY_W-1:0]      rd_rem_r;
  logic [ptt_pkg::CNT_W-1:0]        rd_cnt_data_r;

  logic [ptt_pkg::TASK_W-1:0]       s_task;
  logic [ptt_pkg::DELAY_W-1:0]      s_reload;
  logic [ptt_pkg::DELAY_W-1:0]      s_rem;
  logic signed [ptt_pkg::CNT_W-1:0] s_cnt;

  // tick arithmetic
  logic [ptt_pkg::DELAY_W:0]        diff;
  logic                             expire, tick_live, fire_rep, push_hold;
  logic signed [ptt_pkg::CNT_W-1:0] cnt_new;
  logic [ptt_pkg::DELAY_W-1:0]      rem_new;

  // insert/remove search
  logic                             match_vld_r, free_vld_r;
  logic [IW-1:0]                    match_idx_r, free_idx_r;
  logic                             hit, free_hit;

  // fire collection
  logic                             hold_vld_r;
  logic [ptt_pkg::TASK_W-1:0]       hold_task_r;
  logic [NW-1:0]                    n_r;

  // commit
  logic                             cm_ins, cm_rem, ins_ok, res_ok_r;
  logic [IW-1:0]                    cm_idx;
  logic                             we_meta, we_state;
  logic [IW-1:0]                    wr_idx;
  logic [ptt_pkg::DELAY_W-1:0]      wr_rem;
  logic [ptt_pkg::CNT_W-1:0]        wr_cnt;

  // output register
  logic                             out_busy, fin_push, out_push;
  logic                             out_valid_r;
  logic [ptt_pkg::KIND_W-1:0]       out_kind_r, fin_kind;
  logic                             out_ok_r, fin_ok;
  logic [ptt_pkg::TASK_W-1:0]       out_task_r, fin_task;
  logic                             out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      id_r    <= in_task_id;
      delay_r <= in_delay;
      rc_r    <= in_repeat;
      el_r    <= in_elapsed;
    end
  end

  // ---------------- walk: stage 0 issues reads, stage 1 processes
  assign rd_idx = rd_cnt_r[IW-1:0];
  assign adv    = !stall;
  assign iss    = cmd.walk && adv && (rd_cnt_r != END_CNT);
  assign p_go   = p_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      p_vld_r  <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r <= '0;
      p_vld_r  <= 1'b0;
    end else begin
      if (iss) rd_cnt_r <= rd_cnt_r + CW'(1);
      if (adv) p_vld_r  <= iss;
    end
  end

  always_ff @(posedge clk) begin
    if (iss) begin
      p_idx_r       <= rd_idx;
      rd_v_r        <= slot_vld_r[rd_idx];
      rd_task_r     <= mem_task[rd_idx];
      rd_reload_r   <= mem_reload[rd_idx];
      rd_rem_r      <= mem_rem[rd_idx];
      rd_cnt_data_r <= mem_cnt[rd_idx];
    end
  end

  // never-written slot reads as zero
  assign s_task   = rd_v_r ? rd_task_r : '0;
  assign s_reload = rd_v_r ? rd_reload_r : '0;
  assign s_rem    = rd_v_r ? rd_rem_r : '0;
  assign s_cnt    = rd_v_r ? $signed(rd_cnt_data_r) : '0;

  // saturating countdown, then count and reload
  assign diff    = {1'b0, s_rem} - {1'b0, el_r};
  assign expire  = diff[ptt_pkg::DELAY_W] || (diff[ptt_pkg::DELAY_W-1:0] == '0);
  assign cnt_new = (expire && s_cnt > 0) ? s_cnt - 16'sd1 : s_cnt;
  assign rem_new = !expire ? diff[ptt_pkg::DELAY_W-1:0] :
                   (cnt_new != 0) ? s_reload : '0;

  assign tick_live = p_vld_r && (op_r == ptt_pkg::OP_TICK) && (s_rem != '0);
  // stall only when a fire must displace the held one and the output is full
  assign stall     = tick_live && expire && (n_r != RES_CAP) && hold_vld_r && out_busy;
  assign fire_rep  = p_go && tick_live && expire && (n_r != RES_CAP);
  assign push_hold = fire_rep && hold_vld_r;

  assign hit      = (id_r != '0) && (s_task == id_r);
  assign free_hit = (s_cnt == 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      n_r         <= '0;
    end else if (cmd.load) begin
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      n_r         <= '0;
    end else begin
      if (p_go && hit && !match_vld_r)     match_vld_r <= 1'b1;
      if (p_go && free_hit && !free_vld_r) free_vld_r  <= 1'b1;
      if (fire_rep) begin
        hold_vld_r <= 1'b1;
        n_r        <= n_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_go && hit && !match_vld_r)     match_idx_r <= p_idx_r;
    if (p_go && free_hit && !free_vld_r) free_idx_r  <= p_idx_r;
    if (fire_rep)                        hold_task_r <= s_task;
  end

  // ---------------- commit of insert / remove
  assign cm_ins = cmd.commit && (op_r == ptt_pkg::OP_INSERT);
  assign cm_rem = cmd.commit && (op_r == ptt_pkg::OP_REMOVE);
  assign ins_ok = (id_r != '0) && (match_vld_r || free_vld_r);
  assign cm_idx = match_vld_r ? match_idx_r : free_idx_r;

  assign we_meta  = cm_ins && ins_ok;
  assign we_state = (p_go && tick_live) || we_meta || (cm_rem && match_vld_r);
  assign wr_idx   = cmd.commit ? cm_idx : p_idx_r;
  assign wr_rem   = cmd.commit ? (cm_ins ? delay_r : '0) : rem_new;
  assign wr_cnt   = cmd.commit ? (cm_ins ? rc_r : '0) : cnt_new;

  always_ff @(posedge clk) begin
    if (we_meta) begin
      mem_task[wr_idx]   <= id_r;
      mem_reload[wr_idx] <= delay_r;
    end
    if (we_state) begin
      mem_rem[wr_idx] <= wr_rem;
      mem_cnt[wr_idx] <= wr_cnt;
    end
    if (cmd.commit) res_ok_r <= cm_ins ? ins_ok : match_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (we_meta) begin
      slot_vld_r[wr_idx] <= 1'b1;
    end
  end

  // ---------------- output register
  assign out_busy = out_valid_r && !out_ready;
  assign fin_push = cmd.finish && !out_busy;
  assign out_push = push_hold || fin_push;

  always_comb begin
    fin_kind = ptt_pkg::KIND_QUIET;
    fin_ok   = 1'b0;
    fin_task = '0;
    case (op_r)
      ptt_pkg::OP_INSERT: begin
        fin_kind = ptt_pkg::KIND_INSERT;
        fin_ok   = res_ok_r;
      end
      ptt_pkg::OP_REMOVE: begin
        fin_kind = ptt_pkg::KIND_REMOVE;
        fin_ok   = res_ok_r;
      end
      ptt_pkg::OP_TICK: begin
        if (hold_vld_r) begin
          fin_kind = ptt_pkg::KIND_FIRE;
          fin_task = hold_task_r;
        end
      end
      default: fin_kind = ptt_pkg::KIND_QUIET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hold) begin
      out_kind_r <= ptt_pkg::KIND_FIRE;
      out_ok_r   <= 1'b0;
      out_task_r <= hold_task_r;
      out_last_r <= 1'b0;
    end else if (fin_push) begin
      out_kind_r <= fin_kind;
      out_ok_r   <= fin_ok;
      out_task_r <= fin_task;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_ok    = out_ok_r;
  assign out_task  = out_task_r;
  assign out_last  = out_last_r;

  assign stat.walk_done = p_go && (p_idx_r == LAST_IDX);
  assign stat.out_free  = !out_busy;
  assign stat.op        = op_r;

  // ---------------- checks
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> cmd.walk)
    else $error("slot pipeline busy outside the walk");

  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CAP)
    else $error("fire counter past the result cap");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !(out_valid_r && !out_ready))
    else $error("output register overwritten while stalled");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    stat.walk_done |-> rd_cnt_r == END_CNT)
    else $error("walk ended before every slot was read");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> n_r != '0)
    else $error("held fire without a counted result");

endmodule

`default_nettype wire

// File: hdl/periodic_task_timer_table.sv
`default_nettype none

// Timer slot table: insert/update, remove and tick commands on one stream.
// in_*  : one beat per command (opcode, task id, delay, repeat count, elapsed).
// out_* : result beats. tuser carries the result kind, tlast closes the
//         results of one command. Insert/remove/unknown answer one beat; a
//         tick answers one beat per expiring slot in slot order (at most
//         MAX_RES), or a single "nothing fired" beat.
// Timing: every command sweeps the table one slot per cycle through a
// registered-read slot memory, unless a stalled output holds the sweep;
// insert/remove add a write-back state before the closing result. The
// sweep sets the rate; in_tready is high only between commands.
// Fire beats leave through a one-deep hold plus the output register: the
// sweep pauses only when a new fire meets a full hold and a full output register.
// Reset: rst_n (synchronous) marks every slot empty; entries read back as
// zero until first written, so no clearing pass is needed.
// Back-pressure: out_tready low holds the current beat; the next command is
// taken while its predecessor's last beat still waits.

module periodic_task_timer_table #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata, from bit 0: opcode[1:0], task_id[17:2], delay_ticks[49:18],
  // repeat_count[65:50], elapsed[97:66], zero pad
  input  wire [ptt_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // out_tdata, from bit 0: ok[0], fired_task[16:1], zero pad
  output logic [ptt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: kind[1:0]
  output logic [ptt_pkg::KIND_W-1:0]          out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  wire                                 out_tready
);

  ptt_pkg::ptt_cmd_t  cmd;
  ptt_pkg::ptt_stat_t stat;

  logic                       res_ok;
  logic [ptt_pkg::TASK_W-1:0] res_task;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_tdata[1:0]),
    .in_task_id (in_tdata[17:2]),
    .in_delay   (in_tdata[49:18]),
    .in_repeat  ($signed(in_tdata[65:50])),
    .in_elapsed (in_tdata[97:66]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_ok     (res_ok),
    .out_task   (res_task),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, res_task, res_ok};

endmodule

`default_nettype wire
